@@ rtl/lgjd_pkg.sv @@
// Shared constants and types for the label grid junction detector.
package lgjd_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;
  localparam int LABEL_BITS_DEF = 16;

  localparam int CFG_BITS   = 11;
  localparam int NODE_BITS  = 20;
  localparam int COORD_BITS = 10;
  localparam int COUNT_BITS = 3;
  localparam int CELL_BITS  = 16;
  localparam int ADDR_BITS  = 3;
  localparam int DATA_BITS  = 32;

  localparam logic [CFG_BITS-1:0] SIZE_RESET = 11'd1024;

  typedef enum logic {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } reg_idx_e;

endpackage

@@ rtl/label_grid_junction_detector_top.sv @@
// Junction node detector over a streamed cell label image with 2x2 corner windows.
// After acceptance a request passes through the input register and then the result register.
// Throughput: one request per cycle while the receiver takes results; the row store is read at acceptance and
// written when the request leaves the input register, with a bypass when both touch the same column.
// Reset clears position, node counter and neighbor labels and sets both sizes to 1024.
// The row store has no reset and needs no clearing pass.
module label_grid_junction_detector_top #(
  parameter int MAX_WIDTH  = lgjd_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = lgjd_pkg::MAX_HEIGHT_DEF,
  parameter int LABEL_BITS = lgjd_pkg::LABEL_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lgjd_pkg::ADDR_BITS-1:0]      paddr,
  input  logic [lgjd_pkg::DATA_BITS-1:0]      pwdata,
  output logic [lgjd_pkg::DATA_BITS-1:0]      prdata,
  output logic                                pready,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                frame_start_i,
  input  logic [LABEL_BITS-1:0]               label_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                is_node_o,
  output logic [lgjd_pkg::NODE_BITS-1:0]      node_index_o,
  output logic [lgjd_pkg::COORD_BITS-1:0]     corner_x_o,
  output logic [lgjd_pkg::COORD_BITS-1:0]     corner_y_o,
  output logic [lgjd_pkg::COUNT_BITS-1:0]     cell_count_o,
  output logic [lgjd_pkg::CELL_BITS-1:0]      cell_first_o,
  output logic [lgjd_pkg::CELL_BITS-1:0]      cell_second_o,
  output logic [lgjd_pkg::CELL_BITS-1:0]      cell_third_o,
  output logic [lgjd_pkg::CELL_BITS-1:0]      cell_fourth_o
);

  localparam int XW  = $clog2(MAX_WIDTH);
  localparam int YW  = $clog2(MAX_HEIGHT);
  localparam int XYW = (XW > YW) ? XW : YW;
  localparam int CW  = ((XYW > lgjd_pkg::CFG_BITS) ? XYW : lgjd_pkg::CFG_BITS) + 2;
  localparam int LW  = LABEL_BITS;
  localparam int OW  = lgjd_pkg::CELL_BITS;

  // Configuration registers.
  logic [lgjd_pkg::CFG_BITS-1:0] width_q, height_q;
  logic                          cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= lgjd_pkg::SIZE_RESET;
      height_q <= lgjd_pkg::SIZE_RESET;
    end else if (cfg_wr) begin
      unique case (lgjd_pkg::reg_idx_e'(paddr[2]))
        lgjd_pkg::REG_IMAGE_WIDTH:  width_q  <= pwdata[lgjd_pkg::CFG_BITS-1:0];
        lgjd_pkg::REG_IMAGE_HEIGHT: height_q <= pwdata[lgjd_pkg::CFG_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (lgjd_pkg::reg_idx_e'(paddr[2]))
      lgjd_pkg::REG_IMAGE_WIDTH:  prdata = lgjd_pkg::DATA_BITS'(width_q);
      lgjd_pkg::REG_IMAGE_HEIGHT: prdata = lgjd_pkg::DATA_BITS'(height_q);
      default:                    prdata = '0;
    endcase
  end

  // Handshake control.
  logic s1_valid_q, out_valid_q;
  logic in_acc, s1_adv;

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_acc     = in_valid_i && in_ready_o;

  // Position tracking at acceptance.
  logic [XW-1:0] col_q;
  logic [YW-1:0] row_q;
  logic [CW-1:0] w_eff, h_eff, w_ext, h_ext;
  logic [CW-1:0] col0, row0, col1, row1, x_cur, y_cur, x_nxt, y_nxt;

  always_comb begin
    w_ext = CW'(width_q);
    h_ext = CW'(height_q);
    if (w_ext == '0) begin
      w_eff = CW'(1);
    end else if (w_ext > CW'(MAX_WIDTH)) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = w_ext;
    end
    if (h_ext == '0) begin
      h_eff = CW'(1);
    end else if (h_ext > CW'(MAX_HEIGHT)) begin
      h_eff = CW'(MAX_HEIGHT);
    end else begin
      h_eff = h_ext;
    end

    col0 = frame_start_i ? '0 : CW'(col_q);
    row0 = frame_start_i ? '0 : CW'(row_q);
    if (col0 >= w_eff) begin
      col1 = '0;
      row1 = row0 + CW'(1);
    end else begin
      col1 = col0;
      row1 = row0;
    end
    x_cur = col1;
    y_cur = (row1 >= h_eff) ? '0 : row1;

    x_nxt = x_cur + CW'(1);
    y_nxt = y_cur;
    if (x_nxt >= w_eff) begin
      x_nxt = '0;
      y_nxt = y_cur + CW'(1);
      if (y_nxt >= h_eff) begin
        y_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_acc) begin
      col_q <= x_nxt[XW-1:0];
      row_q <= y_nxt[YW-1:0];
    end
  end

  // Stage one registers.
  logic          s1_fs_q;
  logic [LW-1:0] s1_lbl_q;
  logic [XW-1:0] s1_x_q;
  logic [YW-1:0] s1_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_fs_q  <= frame_start_i;
      s1_lbl_q <= label_i;
      s1_x_q   <= x_cur[XW-1:0];
      s1_y_q   <= y_cur[YW-1:0];
    end
  end

  // Row store with bypass for a write and read of the same column.
  logic [LW-1:0] row_mem [MAX_WIDTH];
  logic [LW-1:0] rd_data_q, fwd_lbl_q;
  logic          fwd_q;

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      row_mem[s1_x_q] <= s1_lbl_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rd_data_q <= row_mem[x_cur[XW-1:0]];
      fwd_q     <= s1_adv && (s1_x_q == x_cur[XW-1:0]);
      fwd_lbl_q <= s1_lbl_q;
    end
  end

  // Window, sort and node decision.
  logic [LW-1:0]                   left_q, ul_q;
  logic [lgjd_pkg::NODE_BITS-1:0]  node_cnt_q, node_base;
  logic [LW-1:0]                   wa, wb, wc, wd;
  logic [LW-1:0]                   v    [4];
  logic [LW-1:0]                   slot [4];
  logic [3:0]                      keep;
  logic [2:0]                      rank [4];
  logic [lgjd_pkg::COUNT_BITS-1:0] n_cells;
  logic                            node;

  always_comb begin
    wb = (s1_y_q != '0) ? (fwd_q ? fwd_lbl_q : rd_data_q) : '0;
    wa = (s1_x_q != '0 && s1_y_q != '0) ? ul_q : '0;
    wc = (s1_x_q != '0) ? left_q : '0;
    wd = s1_lbl_q;
    v[0] = wa;
    v[1] = wb;
    v[2] = wc;
    v[3] = wd;

    for (int i = 0; i < 4; i++) begin
      keep[i] = (v[i] != '0);
      for (int j = 0; j < i; j++) begin
        if (v[j] == v[i]) begin
          keep[i] = 1'b0;
        end
      end
    end

    n_cells = '0;
    for (int i = 0; i < 4; i++) begin
      rank[i] = '0;
      for (int j = 0; j < 4; j++) begin
        if (keep[j] && (v[j] < v[i])) begin
          rank[i] = rank[i] + 3'd1;
        end
      end
      n_cells = n_cells + lgjd_pkg::COUNT_BITS'(keep[i]);
    end

    for (int k = 0; k < 4; k++) begin
      slot[k] = '0;
      for (int i = 0; i < 4; i++) begin
        if (keep[i] && (rank[i] == 3'(k))) begin
          slot[k] = slot[k] | v[i];
        end
      end
    end

    node = (n_cells != '0)
        && !(wa == wb && wb == wc && wc == wd)
        && !(wa == wb && wc == wd && wa != wc)
        && !(wa == wc && wb == wd && wa != wb);

    node_base = s1_fs_q ? '0 : node_cnt_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q     <= '0;
      ul_q       <= '0;
      node_cnt_q <= '0;
    end else if (s1_adv) begin
      left_q     <= wd;
      ul_q       <= wb;
      node_cnt_q <= node_base + lgjd_pkg::NODE_BITS'(node);
    end
  end

  // Result register.
  logic                             is_node_q;
  logic [lgjd_pkg::NODE_BITS-1:0]   node_index_q;
  logic [lgjd_pkg::COORD_BITS-1:0]  corner_x_q, corner_y_q;
  logic [lgjd_pkg::COUNT_BITS-1:0]  cell_count_q;
  logic [OW-1:0]                    cell_q [4];
  logic [CW-1:0]                    x_ext, y_ext;
  logic [LW+OW-1:0]                 slot_ext [4];

  always_comb begin
    x_ext = CW'(s1_x_q);
    y_ext = CW'(s1_y_q);
    for (int k = 0; k < 4; k++) begin
      slot_ext[k] = (LW+OW)'(slot[k]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      is_node_q    <= node;
      node_index_q <= node ? node_base : '0;
      corner_x_q   <= x_ext[lgjd_pkg::COORD_BITS-1:0];
      corner_y_q   <= y_ext[lgjd_pkg::COORD_BITS-1:0];
      cell_count_q <= n_cells;
      for (int k = 0; k < 4; k++) begin
        cell_q[k] <= slot_ext[k][OW-1:0];
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign is_node_o     = is_node_q;
  assign node_index_o  = node_index_q;
  assign corner_x_o    = corner_x_q;
  assign corner_y_o    = corner_y_q;
  assign cell_count_o  = cell_count_q;
  assign cell_first_o  = cell_q[0];
  assign cell_second_o = cell_q[1];
  assign cell_third_o  = cell_q[2];
  assign cell_fourth_o = cell_q[3];

endmodule

@@ rtl/lgjd_checker.sv @@
// Port-level checker for the junction detector and its bind to the top level.
module lgjd_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic                            is_node_o,
  input logic [lgjd_pkg::NODE_BITS-1:0]  node_index_o,
  input logic [lgjd_pkg::COUNT_BITS-1:0] cell_count_o,
  input logic [lgjd_pkg::CELL_BITS-1:0]  cell_first_o,
  input logic [lgjd_pkg::CELL_BITS-1:0]  cell_second_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("Result request dropped before it was taken.");

  a_index_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_node_o |-> node_index_o == '0)
    else $error("Node index is not zero on a corner that is no node.");

  a_node_has_cell: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_node_o |-> cell_count_o != '0)
    else $error("Node reported without any positive label.");

  a_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && cell_count_o >= 3'd2 |-> cell_first_o < cell_second_o)
    else $error("Labels around the corner are not in ascending order.");

endmodule

bind label_grid_junction_detector_top lgjd_checker u_lgjd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .is_node_o     (is_node_o),
  .node_index_o  (node_index_o),
  .cell_count_o  (cell_count_o),
  .cell_first_o  (cell_first_o),
  .cell_second_o (cell_second_o)
);

@@ verif/label_grid_junction_detector_top_tb.sv @@
// Self-checking testbench for the label grid junction detector: corner scoreboard and stimulus.
typedef struct {
  logic                               is_node;
  logic [lgjd_pkg::NODE_BITS-1:0]     node_index;
  logic [lgjd_pkg::COORD_BITS-1:0]    x;
  logic [lgjd_pkg::COORD_BITS-1:0]    y;
  logic [lgjd_pkg::COUNT_BITS-1:0]    count;
  logic [lgjd_pkg::CELL_BITS-1:0]     slots [4];
} corner_t;

class junction_scoreboard;
  logic [lgjd_pkg::CFG_BITS-1:0]   width_reg;
  logic [lgjd_pkg::CFG_BITS-1:0]   height_reg;
  logic [lgjd_pkg::CELL_BITS-1:0]  row_labels [lgjd_pkg::MAX_WIDTH_DEF];
  bit                              row_filled [lgjd_pkg::MAX_WIDTH_DEF];
  logic [lgjd_pkg::CELL_BITS-1:0]  left_lbl;
  logic [lgjd_pkg::CELL_BITS-1:0]  upper_left_lbl;
  int unsigned                     col;
  int unsigned                     row;
  logic [lgjd_pkg::NODE_BITS-1:0]  node_count;
  corner_t                         corners_due [$];
  int unsigned                     mismatches;

  function new();
    width_reg      = lgjd_pkg::SIZE_RESET;
    height_reg     = lgjd_pkg::SIZE_RESET;
    left_lbl       = '0;
    upper_left_lbl = '0;
    col            = 0;
    row            = 0;
    node_count     = '0;
    mismatches     = 0;
  endfunction

  function int unsigned fit_size(logic [lgjd_pkg::CFG_BITS-1:0] v, int unsigned limit);
    if (v == 0) return 1;
    return (v > limit) ? limit : 32'(v);
  endfunction

  function void set_register(lgjd_pkg::reg_idx_e idx, logic [lgjd_pkg::CFG_BITS-1:0] v);
    if (idx == lgjd_pkg::REG_IMAGE_WIDTH) begin
      width_reg = v;
    end else begin
      height_reg = v;
    end
  endfunction

  // True when every column below w holds a label from some earlier pixel.
  function bit columns_filled(int unsigned w);
    for (int unsigned i = 0; i < w; i++) begin
      if (!row_filled[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function void report(string msg);
    mismatches++;
    if (mismatches <= 10) $display("MISMATCH: %s", msg);
  endfunction

  function void take_pixel(bit fs, logic [lgjd_pkg::CELL_BITS-1:0] lbl);
    int unsigned                     w;
    int unsigned                     h;
    logic [lgjd_pkg::CELL_BITS-1:0]  a;
    logic [lgjd_pkg::CELL_BITS-1:0]  b;
    logic [lgjd_pkg::CELL_BITS-1:0]  c;
    logic [lgjd_pkg::CELL_BITS-1:0]  d;
    logic [lgjd_pkg::CELL_BITS-1:0]  win [4];
    logic [lgjd_pkg::CELL_BITS-1:0]  cells [$];
    bit                              dup;
    bit                              node;
    corner_t                         want;
    w = fit_size(width_reg, lgjd_pkg::MAX_WIDTH_DEF);
    h = fit_size(height_reg, lgjd_pkg::MAX_HEIGHT_DEF);
    if (fs) begin
      col        = 0;
      row        = 0;
      node_count = '0;
    end
    if (col >= w) begin
      col = 0;
      row++;
    end
    if (row >= h) row = 0;
    d = lbl;
    b = (row > 0) ? row_labels[col] : '0;
    a = (col > 0 && row > 0) ? upper_left_lbl : '0;
    c = (col > 0) ? left_lbl : '0;
    win = '{a, b, c, d};
    foreach (win[i]) begin
      if (win[i] != 0) begin
        dup = 1'b0;
        foreach (cells[j]) begin
          if (cells[j] == win[i]) dup = 1'b1;
        end
        if (!dup) cells.insert(cells.size(), win[i]);
      end
    end
    cells.sort();
    node = cells.size() > 0
        && !(a == b && b == c && c == d)
        && !(a == b && c == d && a != c)
        && !(a == c && b == d && a != b);
    want.is_node    = node;
    want.node_index = node ? node_count : '0;
    want.x          = lgjd_pkg::COORD_BITS'(col);
    want.y          = lgjd_pkg::COORD_BITS'(row);
    want.count      = lgjd_pkg::COUNT_BITS'(cells.size());
    for (int i = 0; i < 4; i++) begin
      want.slots[i] = (i < cells.size()) ? cells[i] : '0;
    end
    corners_due.insert(corners_due.size(), want);
    if (node) node_count = node_count + 1'b1;
    upper_left_lbl  = b;
    left_lbl        = d;
    row_labels[col] = d;
    row_filled[col] = 1'b1;
    col++;
    if (col >= w) begin
      col = 0;
      row++;
      if (row >= h) row = 0;
    end
  endfunction

  function void compare_field(string field, logic [31:0] want_v, logic [31:0] got_v,
                              corner_t at);
    if (want_v !== got_v) begin
      report($sformatf("corner (%0d,%0d) %s expected %0h actual %0h",
                       at.x, at.y, field, want_v, got_v));
    end
  endfunction

  function void check_corner(corner_t got);
    corner_t want;
    if (corners_due.size() == 0) begin
      report($sformatf("corner (%0d,%0d) arrived with no request outstanding", got.x, got.y));
      return;
    end
    want = corners_due.pop_front();
    compare_field("is_node", 32'(want.is_node), 32'(got.is_node), want);
    compare_field("node_index", 32'(want.node_index), 32'(got.node_index), want);
    compare_field("corner_x", 32'(want.x), 32'(got.x), want);
    compare_field("corner_y", 32'(want.y), 32'(got.y), want);
    compare_field("cell_count", 32'(want.count), 32'(got.count), want);
    foreach (want.slots[i]) begin
      compare_field($sformatf("cell slot %0d", i), 32'(want.slots[i]), 32'(got.slots[i]),
                    want);
    end
  endfunction
endclass

module label_grid_junction_detector_top_tb;

  typedef enum int unsigned {
    RX_OPEN,
    RX_MOSTLY,
    RX_SPARSE,
    RX_EVERY_FOURTH
  } rx_mode_e;

  localparam int unsigned FRAME_MARK = 32'h1_0000;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned HIST_DEPTH = 1100;

  logic                                clk_i = 1'b0;
  logic                                rst_ni;
  logic                                psel;
  logic                                penable;
  logic                                pwrite;
  logic [lgjd_pkg::ADDR_BITS-1:0]      paddr;
  logic [lgjd_pkg::DATA_BITS-1:0]      pwdata;
  logic [lgjd_pkg::DATA_BITS-1:0]      prdata;
  logic                                pready;
  logic                                in_valid_i;
  logic                                in_ready_o;
  logic                                frame_start_i;
  logic [lgjd_pkg::CELL_BITS-1:0]      label_i;
  logic                                out_valid_o;
  logic                                out_ready_i;
  logic                                is_node_o;
  logic [lgjd_pkg::NODE_BITS-1:0]      node_index_o;
  logic [lgjd_pkg::COORD_BITS-1:0]     corner_x_o;
  logic [lgjd_pkg::COORD_BITS-1:0]     corner_y_o;
  logic [lgjd_pkg::COUNT_BITS-1:0]     cell_count_o;
  logic [lgjd_pkg::CELL_BITS-1:0]      cell_first_o;
  logic [lgjd_pkg::CELL_BITS-1:0]      cell_second_o;
  logic [lgjd_pkg::CELL_BITS-1:0]      cell_third_o;
  logic [lgjd_pkg::CELL_BITS-1:0]      cell_fourth_o;

  junction_scoreboard                  sb;
  logic [lgjd_pkg::CELL_BITS-1:0]      sent_hist [$];
  int unsigned                         pixels_taken = 0;
  int unsigned                         nodes_seen = 0;
  int unsigned                         widest_count = 0;
  int unsigned                         settings_used = 0;
  int unsigned                         hold_off_asks = 0;

  // Directed frames on a 4x3 image; bit 16 marks a frame start.
  int unsigned directed_px [26] = '{
    FRAME_MARK | 0, 0, 7, 7,
    5, 5, 7, 7,
    5, 9, 7, 16'hFFFF,
    1, 2, 3, 4,
    16'hFFFF, 4, 3, 2,
    FRAME_MARK | 8, 0, 8, 8,
    8, 0
  };

  label_grid_junction_detector_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .frame_start_i (frame_start_i),
    .label_i       (label_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .is_node_o     (is_node_o),
    .node_index_o  (node_index_o),
    .corner_x_o    (corner_x_o),
    .corner_y_o    (corner_y_o),
    .cell_count_o  (cell_count_o),
    .cell_first_o  (cell_first_o),
    .cell_second_o (cell_second_o),
    .cell_third_o  (cell_third_o),
    .cell_fourth_o (cell_fourth_o)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin : monitor
    corner_t got;
    if (rst_ni && in_valid_i && in_ready_o) begin
      sb.take_pixel(frame_start_i, label_i);
      pixels_taken++;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.is_node    = is_node_o;
      got.node_index = node_index_o;
      got.x          = corner_x_o;
      got.y          = corner_y_o;
      got.count      = cell_count_o;
      got.slots[0]   = cell_first_o;
      got.slots[1]   = cell_second_o;
      got.slots[2]   = cell_third_o;
      got.slots[3]   = cell_fourth_o;
      if (is_node_o === 1'b1) nodes_seen++;
      if (32'(cell_count_o) > widest_count) widest_count = 32'(cell_count_o);
      sb.check_corner(got);
    end
  end

  initial begin : receiver
    rx_mode_e    mode;
    int unsigned seg;
    int unsigned hold;
    int unsigned tick;
    int unsigned asks_seen;
    mode        = RX_OPEN;
    seg         = 0;
    hold        = 0;
    tick        = 0;
    asks_seen   = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_asks != asks_seen) begin
        asks_seen = hold_off_asks;
        hold      = HOLD_OFF_CYCLES;
      end
      if (hold > 0) begin
        hold--;
        out_ready_i <= 1'b0;
      end else begin
        if (seg == 0) begin
          seg  = $urandom_range(20, 200);
          mode = rx_mode_e'($urandom_range(RX_OPEN, RX_EVERY_FOURTH));
        end
        seg--;
        tick++;
        case (mode)
          RX_OPEN:   out_ready_i <= 1'b1;
          RX_MOSTLY: out_ready_i <= ($urandom_range(0, 3) != 0);
          RX_SPARSE: out_ready_i <= ($urandom_range(0, 2) == 0);
          default:   out_ready_i <= (tick % 4 == 0);
        endcase
      end
    end
  end

  initial begin : watchdog
    #(12 * 300000);
    $display("Verification failed");
    $finish;
  end

  task automatic apb_transfer(bit wr, lgjd_pkg::reg_idx_e idx,
                              logic [lgjd_pkg::DATA_BITS-1:0] wdata,
                              output logic [lgjd_pkg::DATA_BITS-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= lgjd_pkg::ADDR_BITS'(4 * int'(idx));
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_register(lgjd_pkg::reg_idx_e idx, logic [lgjd_pkg::CFG_BITS-1:0] value);
    logic [lgjd_pkg::DATA_BITS-1:0] rd;
    apb_transfer(1'b0, idx, '0, rd);
    if (rd !== lgjd_pkg::DATA_BITS'(value)) begin
      sb.report($sformatf("register %s read expected %0d actual %0h", idx.name(), value, rd));
    end
  endtask

  task automatic write_register(lgjd_pkg::reg_idx_e idx, logic [lgjd_pkg::CFG_BITS-1:0] value);
    logic [lgjd_pkg::DATA_BITS-1:0] rd;
    apb_transfer(1'b1, idx, lgjd_pkg::DATA_BITS'(value), rd);
    sb.set_register(idx, value);
    settings_used++;
    check_register(idx, value);
  endtask

  task automatic send_pixel(bit fs, logic [lgjd_pkg::CELL_BITS-1:0] lbl);
    int unsigned target;
    target = pixels_taken + 1;
    in_valid_i    <= 1'b1;
    frame_start_i <= fs;
    label_i       <= lbl;
    do @(negedge clk_i); while (pixels_taken != target);
    sent_hist.insert(sent_hist.size(), lbl);
    if (sent_hist.size() > HIST_DEPTH) void'(sent_hist.pop_front());
  endtask

  task automatic wait_drained();
    while (sb.corners_due.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Mostly repeats a neighbor or draws from a small label set, so that boundaries and
  // uniform windows appear as often as true junctions.
  function automatic logic [lgjd_pkg::CELL_BITS-1:0] pick_label(
      int unsigned w, logic [lgjd_pkg::CELL_BITS-1:0] base);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 25 && sent_hist.size() > 0) return sent_hist[$];
    if (r < 45 && sent_hist.size() >= w) return sent_hist[sent_hist.size() - w];
    if (r < 85) begin
      r = $urandom_range(0, 4);
      return (r == 0) ? '0 : lgjd_pkg::CELL_BITS'(base + r - 1);
    end
    return lgjd_pkg::CELL_BITS'($urandom_range(0, 16'hFFFF));
  endfunction

  task automatic run_phase(logic [lgjd_pkg::CFG_BITS-1:0] w_val,
                           logic [lgjd_pkg::CFG_BITS-1:0] h_val,
                           int unsigned n, bit hold);
    int unsigned                    w;
    int unsigned                    frame_len;
    int unsigned                    pos;
    int unsigned                    burst;
    int unsigned                    gap;
    bit                             gappy;
    bit                             fs;
    bit                             fs_next;
    logic [lgjd_pkg::CELL_BITS-1:0] base;
    wait_drained();
    if (w_val != sb.width_reg) write_register(lgjd_pkg::REG_IMAGE_WIDTH, w_val);
    if (h_val != sb.height_reg) write_register(lgjd_pkg::REG_IMAGE_HEIGHT, h_val);
    w         = sb.fit_size(w_val, lgjd_pkg::MAX_WIDTH_DEF);
    frame_len = w * sb.fit_size(h_val, lgjd_pkg::MAX_HEIGHT_DEF);
    base      = lgjd_pkg::CELL_BITS'($urandom_range(1, 16'hFFFF));
    gappy     = ($urandom_range(0, 2) != 0);
    fs_next   = !sb.columns_filled(w) || ($urandom_range(0, 3) != 0);
    pos       = 0;
    burst     = 0;
    if (hold) hold_off_asks++;
    for (int unsigned i = 0; i < n; i++) begin
      if (gappy && burst == 0) begin
        burst = $urandom_range(1, 40);
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 5);
        if (gap != 0) begin
          in_valid_i <= 1'b0;
          repeat (gap) @(negedge clk_i);
        end
      end
      if (gappy) burst--;
      if (pos == frame_len) begin
        pos     = 0;
        fs_next = ($urandom_range(0, 4) != 0);
      end
      fs = fs_next || ($urandom_range(0, 99) < 2);
      if (fs) pos = 0;
      fs_next = 1'b0;
      send_pixel(fs, pick_label(w, base));
      pos++;
    end
    in_valid_i <= 1'b0;
  endtask

  initial begin : stimulus
    int unsigned                   random_items;
    int unsigned                   phase_no;
    int unsigned                   n;
    int unsigned                   pick;
    logic [lgjd_pkg::CFG_BITS-1:0] w_val;
    logic [lgjd_pkg::CFG_BITS-1:0] h_val;
    sb            = new();
    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_valid_i    = 1'b0;
    frame_start_i = 1'b0;
    label_i       = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    check_register(lgjd_pkg::REG_IMAGE_WIDTH, lgjd_pkg::SIZE_RESET);
    check_register(lgjd_pkg::REG_IMAGE_HEIGHT, lgjd_pkg::SIZE_RESET);
    write_register(lgjd_pkg::REG_IMAGE_WIDTH, 11'd4);
    write_register(lgjd_pkg::REG_IMAGE_HEIGHT, 11'd3);
    foreach (directed_px[i]) begin
      send_pixel(directed_px[i][16], directed_px[i][15:0]);
    end
    in_valid_i <= 1'b0;

    run_phase(11'd1024, 11'd1024, 1100, 1'b1);
    run_phase(11'd1, 11'd1024, 40, 1'b0);
    run_phase(11'd0, 11'd0, 20, 1'b0);
    run_phase(11'd2047, 11'd1500, 80, 1'b0);
    run_phase(11'd2, 11'd1, 30, 1'b0);

    random_items = 0;
    phase_no     = 0;
    while (random_items < 120) begin
      pick  = $urandom_range(0, 9);
      w_val = lgjd_pkg::CFG_BITS'((pick < 7) ? $urandom_range(1, 16) :
              (pick < 9) ? $urandom_range(17, 64) : $urandom_range(0, 2047));
      pick  = $urandom_range(0, 9);
      h_val = lgjd_pkg::CFG_BITS'((pick < 8) ? $urandom_range(1, 12) :
                                  $urandom_range(0, 2047));
      n     = $urandom_range(20, 60);
      run_phase(w_val, h_val, n, (phase_no % 5 == 2));
      random_items += n;
      phase_no++;
    end

    n = 0;
    while (sb.corners_due.size() != 0 && n < 20000) begin
      @(negedge clk_i);
      n++;
    end
    repeat (8) @(negedge clk_i);
    if (sb.corners_due.size() != 0) begin
      sb.report($sformatf("%0d corners never arrived", sb.corners_due.size()));
    end
    $display("Checked %0d pixels, %0d junction nodes, up to %0d labels per corner, %0d size writes.",
             pixels_taken, nodes_seen, widest_count, settings_used);
    $display("Frame restarts, mid-frame size changes, out-of-range sizes and %0d receiver hold-offs.",
             hold_off_asks);
    if (sb.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

@@ files.f @@
rtl/lgjd_pkg.sv
rtl/label_grid_junction_detector_top.sv
rtl/lgjd_checker.sv
verif/label_grid_junction_detector_top_tb.sv
